// ===== rtl/swfsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// swfsrd_pkg
// types, codes and helpers shared by the shape record decoder files
// ----------------------------------------------------------------------------
package swfsrd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STYLES_ALLOWED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COUNT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT     = 2'd3;

    localparam logic [2:0] K_MOVE      = 3'd0;
    localparam logic [2:0] K_LINE      = 3'd1;
    localparam logic [2:0] K_CURVE     = 3'd2;
    localparam logic [2:0] K_STYLE     = 3'd3;
    localparam logic [2:0] K_END       = 3'd4;
    localparam logic [2:0] K_NEWSTYLES = 3'd5;

    localparam logic [4:0] FL_MOVE  = 5'h01;
    localparam logic [4:0] FL_FILL0 = 5'h02;
    localparam logic [4:0] FL_FILL1 = 5'h04;
    localparam logic [4:0] FL_LINE  = 5'h08;
    localparam logic [4:0] FL_NEW   = 5'h10;

    typedef enum logic [4:0] {
        PH_IDLE, PH_TYPE, PH_FLAGS, PH_MOVEBITS, PH_MOVEX, PH_MOVEY,
        PH_FILL0, PH_FILL1, PH_LINE, PH_STRAIGHT, PH_NBITS, PH_CX, PH_CY,
        PH_AX, PH_AY, PH_LINEFLAG, PH_VERTFLAG, PH_GDX, PH_GDY, PH_HDX, PH_VDY
    } ph_t;

    typedef enum logic [1:0] {
        CS_IDLE, CS_BIT, CS_CHAIN, CS_OUT
    } ctl_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_t;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] ctrl_x;
        logic signed [31:0] ctrl_y;
        logic [14:0]        left_fill;
        logic [14:0]        right_fill;
        logic [14:0]        line_index;
        logic               last;
    } out_t;

    // next style field to read, PH_IDLE when the record is complete
    function automatic ph_t style_sel(input ph_t from, input logic [4:0] f,
                                      input logic [3:0] fw, input logic [3:0] lw);
        ph_t r;
        r = PH_IDLE;
        if (from == PH_FILL0 && (f & FL_FILL0) != 5'd0 && fw != 4'd0)
            r = PH_FILL0;
        else if ((from == PH_FILL0 || from == PH_FILL1) && (f & FL_FILL1) != 5'd0
                 && fw != 4'd0)
            r = PH_FILL1;
        else if ((f & FL_LINE) != 5'd0 && lw != 4'd0)
            r = PH_LINE;
        return r;
    endfunction

endpackage

// ===== rtl/swf_shape_record_decoder_top.sv =====
// ----------------------------------------------------------------------------
// swf_shape_record_decoder_top
// bit-serial decoder of shape records with absolute pen tracking
// ----------------------------------------------------------------------------
//  channel  direction  signals                       payload
//  in       input      in_valid / in_ready           in_data (in_t)
//  out      output     out_valid / out_ready         out_data (out_t)
//  cfg      input      cfg_we                        cfg_index, cfg_data
//
//  a start byte, or a byte that arrives while no shape is open, is handled when
//  it is accepted; any other byte is shifted in one bit at a time, up to 8 bits,
//  fewer when the shape ends inside it, with one chain step for each zero-width
//  field completed after a bit; the results are then handed out one at a time
//  while out_ready is high
//  in_ready is high only while no byte is in work and no result is pending
//  rst_n resets control, config and decoder state asynchronously
// ----------------------------------------------------------------------------
module swf_shape_record_decoder_top
    import swfsrd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = COORD_WIDTH;

    function automatic logic [CW-1:0] sx(input logic [30:0] a, input logic [4:0] n);
        logic [CW-1:0] r;
        logic          s;
        s = (n != 5'd0) ? a[n - 5'd1] : 1'b0;
        for (int i = 0; i < CW; i++)
        begin
            if (i < 31 && i < int'(n))
                r[i] = a[i];
            else
                r[i] = s;
        end
        return r;
    endfunction

    function automatic logic [31:0] ext32(input logic [CW-1:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = (i < CW) ? v[i] : v[CW-1];
        end
        return r;
    endfunction

    logic              sa_reg, font_reg;
    logic [15:0]       fcnt_reg, lcnt_reg;
    ctl_t              cs_reg, cs_next;
    ph_t               ph_reg, ph_next;
    logic [30:0]       acc_reg, acc_next;
    logic [4:0]        bl_reg, bl_next, fl_reg, fl_next, fw_reg, fw_next;
    logic [3:0]        fillw_reg, fillw_next, linew_reg, linew_next;
    logic [CW-1:0]     px_reg, px_next, py_reg, py_next, cx_reg, cx_next, cy_reg, cy_next;
    logic [14:0]       lf_reg, lf_next, rf_reg, rf_next, ln_reg, ln_next;
    logic [7:0]        sh_reg, sh_next;
    logic [3:0]        bc_reg, bc_next;
    out_t              b0_reg, b0_next, b1_reg, b1_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              oi_reg, oi_next;

    logic              in_acc, out_acc, cmp, emit, curve;
    logic [2:0]        kind;
    logic [30:0]       a;
    logic [4:0]        bl_dec;
    ph_t               sel;
    logic [4:0]        sf;
    logic [15:0]       flim, llim;
    out_t              rec;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign flim    = font_reg ? 16'd1 : fcnt_reg;
    assign llim    = font_reg ? 16'd1 : lcnt_reg;

    always_comb
    begin
        ph_next    = ph_reg;
        acc_next   = acc_reg;
        bl_next    = bl_reg;
        fl_next    = fl_reg;
        fw_next    = fw_reg;
        fillw_next = fillw_reg;
        linew_next = linew_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        lf_next    = lf_reg;
        rf_next    = rf_reg;
        ln_next    = ln_reg;
        sh_next    = sh_reg;
        bc_next    = bc_reg;
        emit       = 1'b0;
        curve      = 1'b0;
        kind       = K_END;
        cmp        = 1'b0;
        a          = acc_reg;
        bl_dec     = bl_reg;
        sel        = PH_IDLE;
        sf         = fl_reg;

        if (cs_reg == CS_IDLE && in_acc)
        begin
            if (in_data.start_req)
            begin
                px_next    = '0;
                py_next    = '0;
                cx_next    = '0;
                cy_next    = '0;
                lf_next    = '0;
                rf_next    = '0;
                ln_next    = '0;
                fl_next    = '0;
                fw_next    = '0;
                fillw_next = in_data.data_byte[7:4];
                linew_next = in_data.data_byte[3:0];
                acc_next   = '0;
                if (font_reg && in_data.data_byte == 8'd0)
                begin
                    emit    = 1'b1;
                    kind    = K_END;
                    ph_next = PH_IDLE;
                    bl_next = '0;
                end
                else
                begin
                    ph_next = PH_TYPE;
                    bl_next = 5'd1;
                end
            end
            else
            begin
                sh_next = in_data.data_byte;
                bc_next = '0;
            end
        end
        else if (cs_reg == CS_BIT || cs_reg == CS_CHAIN)
        begin
            if (cs_reg == CS_BIT)
            begin
                a       = {acc_reg[29:0], sh_reg[7]};
                sh_next = {sh_reg[6:0], 1'b0};
                bc_next = bc_reg + 4'd1;
                bl_dec  = (bl_reg != 5'd0) ? bl_reg - 5'd1 : 5'd0;
            end
            acc_next = a;
            bl_next  = bl_dec;
            cmp      = (bl_dec == 5'd0);
            if (cmp)
            begin
                acc_next = '0;
                unique case (ph_reg)
                    PH_TYPE:
                    begin
                        ph_next = a[0] ? PH_STRAIGHT : PH_FLAGS;
                        bl_next = a[0] ? 5'd1 : 5'd5;
                    end
                    PH_FLAGS, PH_MOVEY, PH_FILL0, PH_FILL1, PH_LINE:
                    begin
                        if (ph_reg == PH_FLAGS)
                        begin
                            sf      = a[4:0];
                            fl_next = a[4:0];
                        end
                        if (ph_reg == PH_MOVEY)
                            py_next = sx(a, fw_reg);
                        if (ph_reg == PH_FILL0)
                            lf_next = ({1'b0, a[14:0]} > flim) ? 15'd0 : a[14:0];
                        if (ph_reg == PH_FILL1)
                            rf_next = ({1'b0, a[14:0]} > flim) ? 15'd0 : a[14:0];
                        if (ph_reg == PH_LINE)
                            ln_next = ({1'b0, a[14:0]} > llim) ? 15'd0 : a[14:0];
                        if (ph_reg == PH_FLAGS && sf == 5'd0)
                        begin
                            emit    = 1'b1;
                            kind    = K_END;
                            ph_next = PH_IDLE;
                            bl_next = '0;
                        end
                        else if (ph_reg == PH_FLAGS && (sf & FL_MOVE) != 5'd0)
                        begin
                            ph_next = PH_MOVEBITS;
                            bl_next = 5'd5;
                        end
                        else
                        begin
                            if (ph_reg == PH_LINE)
                                sel = PH_IDLE;
                            else if (ph_reg == PH_FILL1)
                                sel = style_sel(PH_LINE, sf, fillw_reg, linew_reg);
                            else if (ph_reg == PH_FILL0)
                                sel = style_sel(PH_FILL1, sf, fillw_reg, linew_reg);
                            else
                                sel = style_sel(PH_FILL0, sf, fillw_reg, linew_reg);
                            if (sel != PH_IDLE)
                            begin
                                ph_next = sel;
                                bl_next = {1'b0, (sel == PH_LINE) ? linew_reg : fillw_reg};
                            end
                            else if ((sf & FL_NEW) != 5'd0 && sa_reg)
                            begin
                                emit    = 1'b1;
                                kind    = K_NEWSTYLES;
                                ph_next = PH_IDLE;
                                bl_next = '0;
                            end
                            else
                            begin
                                emit    = 1'b1;
                                kind    = ((sf & FL_MOVE) != 5'd0) ? K_MOVE : K_STYLE;
                                ph_next = PH_TYPE;
                                bl_next = 5'd1;
                            end
                        end
                    end
                    PH_MOVEBITS:
                    begin
                        fw_next = a[4:0];
                        ph_next = PH_MOVEX;
                        bl_next = a[4:0];
                    end
                    PH_MOVEX:
                    begin
                        px_next = sx(a, fw_reg);
                        ph_next = PH_MOVEY;
                        bl_next = fw_reg;
                    end
                    PH_STRAIGHT:
                    begin
                        fl_next = {4'd0, a[0]};
                        ph_next = PH_NBITS;
                        bl_next = 5'd4;
                    end
                    PH_NBITS:
                    begin
                        fw_next = 5'd2 + {1'b0, a[3:0]};
                        ph_next = fl_reg[0] ? PH_LINEFLAG : PH_CX;
                        bl_next = fl_reg[0] ? 5'd1 : 5'd2 + {1'b0, a[3:0]};
                    end
                    PH_CX:
                    begin
                        cx_next = px_reg + sx(a, fw_reg);
                        ph_next = PH_CY;
                        bl_next = fw_reg;
                    end
                    PH_CY:
                    begin
                        cy_next = py_reg + sx(a, fw_reg);
                        ph_next = PH_AX;
                        bl_next = fw_reg;
                    end
                    PH_AX:
                    begin
                        px_next = cx_reg + sx(a, fw_reg);
                        ph_next = PH_AY;
                        bl_next = fw_reg;
                    end
                    PH_AY:
                    begin
                        py_next = cy_reg + sx(a, fw_reg);
                        emit    = 1'b1;
                        curve   = 1'b1;
                        kind    = K_CURVE;
                        ph_next = PH_TYPE;
                        bl_next = 5'd1;
                    end
                    PH_LINEFLAG:
                    begin
                        ph_next = a[0] ? PH_GDX : PH_VERTFLAG;
                        bl_next = a[0] ? fw_reg : 5'd1;
                    end
                    PH_VERTFLAG:
                    begin
                        ph_next = a[0] ? PH_VDY : PH_HDX;
                        bl_next = fw_reg;
                    end
                    PH_GDX:
                    begin
                        px_next = px_reg + sx(a, fw_reg);
                        ph_next = PH_GDY;
                        bl_next = fw_reg;
                    end
                    PH_GDY, PH_VDY:
                    begin
                        py_next = py_reg + sx(a, fw_reg);
                        emit    = 1'b1;
                        kind    = K_LINE;
                        ph_next = PH_TYPE;
                        bl_next = 5'd1;
                    end
                    PH_HDX:
                    begin
                        px_next = px_reg + sx(a, fw_reg);
                        emit    = 1'b1;
                        kind    = K_LINE;
                        ph_next = PH_TYPE;
                        bl_next = 5'd1;
                    end
                    default:
                    begin
                        ph_next = PH_IDLE;
                        bl_next = '0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        rec.record_kind = kind;
        rec.pos_x       = ext32(px_next);
        rec.pos_y       = ext32(py_next);
        rec.ctrl_x      = curve ? ext32(cx_next) : 32'd0;
        rec.ctrl_y      = curve ? ext32(cy_next) : 32'd0;
        rec.left_fill   = lf_next;
        rec.right_fill  = rf_next;
        rec.line_index  = ln_next;
        rec.last        = 1'b0;
    end

    always_comb
    begin
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        cnt_next = cnt_reg;
        oi_next  = oi_reg;
        if (cs_reg == CS_IDLE && in_acc)
        begin
            cnt_next = '0;
            oi_next  = 1'b0;
        end
        if (cs_reg == CS_OUT && out_acc)
            oi_next = 1'b1;
        if (emit)
        begin
            if (cs_reg == CS_IDLE)
            begin
                b0_next  = rec;
                cnt_next = 2'd1;
            end
            else if (cnt_reg == 2'd0)
            begin
                b0_next  = rec;
                cnt_next = 2'd1;
            end
            else if (cnt_reg == 2'd1)
            begin
                b1_next  = rec;
                cnt_next = 2'd2;
            end
        end
    end

    // control sequencing
    always_comb
    begin
        cs_next = cs_reg;
        unique case (cs_reg)
            CS_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.start_req)
                        cs_next = emit ? CS_OUT : CS_IDLE;
                    else if (ph_reg != PH_IDLE)
                        cs_next = CS_BIT;
                end
            end
            CS_BIT, CS_CHAIN:
            begin
                if (ph_next == PH_IDLE || (bl_next != 5'd0 && bc_next == 4'd8))
                    cs_next = (cnt_next != 2'd0) ? CS_OUT : CS_IDLE;
                else if (bl_next == 5'd0)
                    cs_next = CS_CHAIN;
                else
                    cs_next = CS_BIT;
            end
            CS_OUT:
            begin
                if (out_acc && (oi_reg || cnt_reg == 2'd1))
                    cs_next = CS_IDLE;
            end
            default: cs_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (cs_reg == CS_IDLE);
        out_valid = (cs_reg == CS_OUT);
        out_data  = oi_reg ? b1_reg : b0_reg;
        out_data.last = oi_reg || cnt_reg == 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg    <= 1'b1;
            font_reg  <= 1'b0;
            fcnt_reg  <= '0;
            lcnt_reg  <= '0;
            cs_reg    <= CS_IDLE;
            ph_reg    <= PH_IDLE;
            acc_reg   <= '0;
            bl_reg    <= '0;
            fl_reg    <= '0;
            fw_reg    <= '0;
            fillw_reg <= '0;
            linew_reg <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            lf_reg    <= '0;
            rf_reg    <= '0;
            ln_reg    <= '0;
            bc_reg    <= '0;
            cnt_reg   <= '0;
            oi_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STYLES_ALLOWED: sa_reg   <= cfg_data[0];
                    CFG_FONT_MODE:      font_reg <= cfg_data[0];
                    CFG_FILL_COUNT:     fcnt_reg <= cfg_data;
                    CFG_LINE_COUNT:     lcnt_reg <= cfg_data;
                    default:            sa_reg   <= sa_reg;
                endcase
            end
            cs_reg    <= cs_next;
            ph_reg    <= ph_next;
            acc_reg   <= acc_next;
            bl_reg    <= bl_next;
            fl_reg    <= fl_next;
            fw_reg    <= fw_next;
            fillw_reg <= fillw_next;
            linew_reg <= linew_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            lf_reg    <= lf_next;
            rf_reg    <= rf_next;
            ln_reg    <= ln_next;
            bc_reg    <= bc_next;
            cnt_reg   <= cnt_next;
            oi_reg    <= oi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

endmodule

// ===== rtl/swfsrd_checker.sv =====
// ----------------------------------------------------------------------------
// swfsrd_props
// port-level checks of the shape record decoder
// ----------------------------------------------------------------------------
module swfsrd_props
    import swfsrd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // no new transaction while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // last result returns to input
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last |=> in_ready && !out_valid)
        else $error("no return to idle after last result");

    // non-last result is followed by another
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid)
        else $error("missing second result");

endmodule

bind swf_shape_record_decoder_top swfsrd_props u_swfsrd_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/swfsrd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swfsrd_checker
// Watches the byte, result and register ports of the shape record decoder.
// A bit-serial copy of the decoder runs on every accepted byte. Each accepted
// result is compared field by field with the oldest predicted record.
// ----------------------------------------------------------------------------
module swfsrd_checker
    import swfsrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    records_due,
    output int                    records_seen
);

    out_t        record_q[$];
    out_t        batch[$];

    logic        m_styles;
    logic        m_font;
    logic [15:0] m_fill_cnt;
    logic [15:0] m_line_cnt;

    ph_t         ph;
    logic [31:0] acc;
    int          bits_left;
    logic [4:0]  flags;
    logic [4:0]  fwid;
    logic [3:0]  fill_w;
    logic [3:0]  line_w;
    logic [31:0] px, py, cx, cy;
    logic [14:0] fl, fr, ln;
    logic        done;

    function automatic logic [31:0] sext(input logic [31:0] v, input int n);
        logic [31:0] m;
        if (n == 0)
            return 32'd0;
        m = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        v = v & m;
        if (v[n-1])
            v = v | ~m;
        return v;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic curve);
        out_t r;
        if (batch.size() >= 2)
            return;
        r.record_kind = kind;
        r.pos_x       = px;
        r.pos_y       = py;
        r.ctrl_x      = curve ? cx : 32'd0;
        r.ctrl_y      = curve ? cy : 32'd0;
        r.left_fill   = fl;
        r.right_fill  = fr;
        r.line_index  = ln;
        r.last        = 1'b0;
        batch.insert(batch.size(), r);
    endfunction

    function automatic void enter(input ph_t p, input int w);
        ph        = p;
        bits_left = w & 31;
        acc       = 32'd0;
    endfunction

    function automatic void stop_shape();
        done = 1'b1;
        enter(PH_IDLE, 0);
    endfunction

    function automatic logic [14:0] clamp_style(input logic [31:0] v, input logic [15:0] cnt);
        logic [31:0] lim;
        lim = m_font ? 32'd1 : {16'd0, cnt};
        return (v > lim) ? 15'd0 : v[14:0];
    endfunction

    function automatic void close_style();
        if ((flags & FL_NEW) != 5'd0 && m_styles)
        begin
            emit(K_NEWSTYLES, 1'b0);
            stop_shape();
            return;
        end
        emit((flags & FL_MOVE) != 5'd0 ? K_MOVE : K_STYLE, 1'b0);
        enter(PH_TYPE, 1);
    endfunction

    function automatic void next_style(input ph_t from);
        if (from <= PH_FILL0 && (flags & FL_FILL0) != 5'd0 && fill_w != 4'd0)
            enter(PH_FILL0, fill_w);
        else if (from <= PH_FILL1 && (flags & FL_FILL1) != 5'd0 && fill_w != 4'd0)
            enter(PH_FILL1, fill_w);
        else if (from <= PH_LINE && (flags & FL_LINE) != 5'd0 && line_w != 4'd0)
            enter(PH_LINE, line_w);
        else
            close_style();
    endfunction

    function automatic void field_done();
        logic [31:0] a;
        int          w;
        a = acc;
        w = fwid;
        case (ph)
            PH_TYPE:      if (a[0]) enter(PH_STRAIGHT, 1); else enter(PH_FLAGS, 5);
            PH_FLAGS:
            begin
                flags = a[4:0];
                if (flags == 5'd0)
                begin
                    emit(K_END, 1'b0);
                    stop_shape();
                end
                else if ((flags & FL_MOVE) != 5'd0)
                    enter(PH_MOVEBITS, 5);
                else
                    next_style(PH_FILL0);
            end
            PH_MOVEBITS:
            begin
                fwid = a[4:0];
                enter(PH_MOVEX, a[4:0]);
            end
            PH_MOVEX:
            begin
                px = sext(a, w);
                enter(PH_MOVEY, w);
            end
            PH_MOVEY:
            begin
                py = sext(a, w);
                next_style(PH_FILL0);
            end
            PH_FILL0:
            begin
                fl = clamp_style(a, m_fill_cnt);
                next_style(PH_FILL1);
            end
            PH_FILL1:
            begin
                fr = clamp_style(a, m_fill_cnt);
                next_style(PH_LINE);
            end
            PH_LINE:
            begin
                ln = clamp_style(a, m_line_cnt);
                close_style();
            end
            PH_STRAIGHT:
            begin
                flags = {4'd0, a[0]};
                enter(PH_NBITS, 4);
            end
            PH_NBITS:
            begin
                fwid = 5'd2 + {1'b0, a[3:0]};
                if (flags[0]) enter(PH_LINEFLAG, 1); else enter(PH_CX, fwid);
            end
            PH_CX:
            begin
                cx = px + sext(a, w);
                enter(PH_CY, w);
            end
            PH_CY:
            begin
                cy = py + sext(a, w);
                enter(PH_AX, w);
            end
            PH_AX:
            begin
                px = cx + sext(a, w);
                enter(PH_AY, w);
            end
            PH_AY:
            begin
                py = cy + sext(a, w);
                emit(K_CURVE, 1'b1);
                enter(PH_TYPE, 1);
            end
            PH_LINEFLAG:  if (a[0]) enter(PH_GDX, w); else enter(PH_VERTFLAG, 1);
            PH_VERTFLAG:  if (a[0]) enter(PH_VDY, w); else enter(PH_HDX, w);
            PH_GDX:
            begin
                px = px + sext(a, w);
                enter(PH_GDY, w);
            end
            PH_GDY, PH_VDY:
            begin
                py = py + sext(a, w);
                emit(K_LINE, 1'b0);
                enter(PH_TYPE, 1);
            end
            PH_HDX:
            begin
                px = px + sext(a, w);
                emit(K_LINE, 1'b0);
                enter(PH_TYPE, 1);
            end
            default:      enter(PH_IDLE, 0);
        endcase
    endfunction

    function automatic void decode_byte(input in_t t);
        batch.delete();
        if (t.start_req)
        begin
            px = 0; py = 0; cx = 0; cy = 0;
            fl = 0; fr = 0; ln = 0;
            flags  = 0;
            fwid   = 0;
            done   = 1'b0;
            fill_w = t.data_byte[7:4];
            line_w = t.data_byte[3:0];
            if (m_font && fill_w == 4'd0 && line_w == 4'd0)
            begin
                emit(K_END, 1'b0);
                stop_shape();
            end
            else
                enter(PH_TYPE, 1);
        end
        else if (ph != PH_IDLE && !done)
        begin
            for (int i = 7; i >= 0; i--)
            begin
                if (ph == PH_IDLE)
                    break;
                acc = {acc[30:0], t.data_byte[i]};
                if (bits_left > 0)
                    bits_left--;
                while (ph != PH_IDLE && bits_left == 0)
                    field_done();
            end
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            record_q.insert(record_q.size(), batch[i]);
    endfunction

    function automatic int cmp(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        int   bad;
        if (!rst_n)
        begin
            m_styles   = 1'b1;
            m_font     = 1'b0;
            m_fill_cnt = 0;
            m_line_cnt = 0;
            ph = PH_IDLE; acc = 0; bits_left = 0; flags = 0; fwid = 0;
            fill_w = 0; line_w = 0;
            px = 0; py = 0; cx = 0; cy = 0;
            fl = 0; fr = 0; ln = 0;
            done = 1'b0;
            record_q.delete();
            fail_count   = 0;
            records_seen = 0;
            records_due  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STYLES_ALLOWED: m_styles   = cfg_data[0];
                    CFG_FONT_MODE:      m_font     = cfg_data[0];
                    CFG_FILL_COUNT:     m_fill_cnt = cfg_data;
                    CFG_LINE_COUNT:     m_line_cnt = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                records_seen++;
                if (record_q.size() == 0)
                begin
                    $error("unexpected result transaction, kind %0d", out_data.record_kind);
                    fail_count++;
                end
                else
                begin
                    e   = record_q.pop_front();
                    bad = 0;
                    bad += cmp("record_kind", e.record_kind, out_data.record_kind);
                    bad += cmp("pos_x", e.pos_x, out_data.pos_x);
                    bad += cmp("pos_y", e.pos_y, out_data.pos_y);
                    bad += cmp("ctrl_x", e.ctrl_x, out_data.ctrl_x);
                    bad += cmp("ctrl_y", e.ctrl_y, out_data.ctrl_y);
                    bad += cmp("left_fill", e.left_fill, out_data.left_fill);
                    bad += cmp("right_fill", e.right_fill, out_data.right_fill);
                    bad += cmp("line_index", e.line_index, out_data.line_index);
                    bad += cmp("last", e.last, out_data.last);
                    if (bad != 0)
                        fail_count++;
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_data);
            records_due = record_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Random shape streams for the shape record decoder.
// Well-formed shapes are built bit by bit from random records of every kind,
// with noise bytes and cut-off shapes mixed in. The register settings are
// changed between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module tb;
    import swfsrd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int BYTE_TARGET = 1350;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int records_due;
    int records_seen;
    int bytes_sent;
    int shapes_sent;
    int quiet_cycles = 0;
    bit calm;
    bit stream[$];
    logic styles_on;
    logic font_on;

    swf_shape_record_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swfsrd_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .records_due  (records_due),
        .records_seen (records_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (!calm)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.data_byte <= b;
        in_data.start_req <= s;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (records_due != 0 || !in_ready)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic sa, input logic fm, input logic [15:0] fc,
                             input logic [15:0] lc);
        drain();
        set_reg(CFG_STYLES_ALLOWED, {15'd0, sa});
        set_reg(CFG_FONT_MODE, {15'd0, fm});
        set_reg(CFG_FILL_COUNT, fc);
        set_reg(CFG_LINE_COUNT, lc);
        styles_on = sa;
        font_on   = fm;
    endtask

    task automatic put_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            stream.insert(stream.size(), v[i]);
    endtask

    task automatic flush_stream();
        logic [7:0] b;
        while (stream.size() % 8 != 0)
            stream.insert(stream.size(), 1'($urandom_range(0, 1)));
        while (stream.size() != 0)
        begin
            for (int i = 7; i >= 0; i--)
                b[i] = stream.pop_front();
            send_byte(b, 1'b0);
        end
    endtask

    function automatic int pick_width(input int hi);
        return ($urandom_range(0, 7) == 0) ? hi : $urandom_range(0, hi < 6 ? hi : 6);
    endfunction

    task automatic put_record(input logic [3:0] fw, input logic [3:0] lw);
        logic [4:0] f;
        int         n;
        case ($urandom_range(0, 3))
            0:
            begin
                put_bits(0, 1);
                f = 5'($urandom_range(1, 31));
                if ($urandom_range(0, 7) != 0)
                    f = f & ~FL_NEW;
                if (f == 5'd0)
                    f = FL_FILL0;
                put_bits({27'd0, f}, 5);
                if ((f & FL_MOVE) != 5'd0)
                begin
                    n = pick_width(31);
                    put_bits(n, 5);
                    put_bits($urandom, n);
                    put_bits($urandom, n);
                end
                if ((f & FL_FILL0) != 5'd0) put_bits($urandom_range(0, 5), int'(fw));
                if ((f & FL_FILL1) != 5'd0) put_bits($urandom, int'(fw));
                if ((f & FL_LINE) != 5'd0)  put_bits($urandom_range(0, 5), int'(lw));
            end
            1, 2:
            begin
                n = pick_width(15);
                put_bits(3, 2);
                put_bits(n, 4);
                case ($urandom_range(0, 2))
                    0: begin put_bits(1, 1); put_bits($urandom, n + 2);
                             put_bits($urandom, n + 2); end
                    1: begin put_bits(1, 2); put_bits($urandom, n + 2); end
                    default: begin put_bits(0, 2); put_bits($urandom, n + 2); end
                endcase
            end
            default:
            begin
                n = pick_width(15);
                put_bits(2, 2);
                put_bits(n, 4);
                repeat (4) put_bits($urandom, n + 2);
            end
        endcase
    endtask

    task automatic random_shape();
        logic [3:0] fw;
        logic [3:0] lw;
        fw = 4'(pick_width(15));
        lw = 4'(pick_width(15));
        if (font_on && $urandom_range(0, 5) == 0)
        begin
            fw = 4'd0;
            lw = 4'd0;
        end
        shapes_sent++;
        send_byte({fw, lw}, 1'b1);
        repeat ($urandom_range(2, 10)) put_record(fw, lw);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 12)) void'(stream.pop_back());
        else
            put_bits(0, 6);
        flush_stream();
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        bytes_sent   = 0;
        shapes_sent  = 0;
        styles_on    = 1'b1;
        font_on      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle noise before any shape, then extremes of the start byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        put_bits(2, 2); put_bits(15, 4);
        put_bits(32'h1FFFF, 17); put_bits(32'h10000, 17);
        put_bits(32'h0FFFF, 17); put_bits(32'h00001, 17);
        put_bits(1, 6); put_bits(0, 5);
        put_bits(0, 6);
        flush_stream();
        send_byte(8'hA5, 1'b0);

        configure(1'b0, 1'b1, 16'd0, 16'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b1);
        put_bits(30, 6); put_bits(1, 1); put_bits(1, 1); put_bits(1, 1);
        put_bits(16, 6);
        put_bits(0, 6);
        flush_stream();

        configure(1'b1, 1'b0, 16'd2, 16'd1);
        send_byte(8'h22, 1'b1);
        put_bits(31, 6); put_bits(0, 5);
        put_bits(3, 2); put_bits(1, 2); put_bits(2, 2);
        flush_stream();
        send_byte(8'h33, 1'b0);
        send_byte(8'h3C, 1'b1);
        put_bits(8, 6);
        send_byte(8'h3C, 1'b1);
        put_bits(0, 6);
        flush_stream();

        for (int p = 0; bytes_sent < BYTE_TARGET; p++)
        begin
            if (p % 12 == 0)
            begin
                case ((p / 12) % 6)
                    0: configure(1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
                    1: configure(1'b1, 1'b0, 16'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 6)));
                    2: configure(1'b0, 1'b1, 16'($urandom), 16'($urandom));
                    3: configure(1'b1, 1'b1, 16'd0, 16'hFFFF);
                    4: configure(1'b1, 1'b0, 16'd0, 16'd0);
                    default: configure(1'($urandom), 1'b0, 16'($urandom),
                                       16'($urandom_range(0, 3)));
                endcase
            end
            if (bytes_sent > (BYTE_TARGET * 4) / 5)
                calm = 1'b1;
            random_shape();
        end

        drain();
        $display("sent %0d bytes in %0d shapes, checked %0d records",
                 bytes_sent, shapes_sent, records_seen);
        $display("covered moves, lines, curves, style changes, ends, new styles, wraps");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== swf_shape_record_decoder_top.f =====
rtl/swfsrd_pkg.sv
rtl/swf_shape_record_decoder_top.sv
rtl/swfsrd_checker.sv
bench/swfsrd_checker.sv
bench/tb.sv
